@@ sv/battery_gauge_smoother_core_assert.svh @@
// ----------------------------------------------------------------------------
// Battery gauge smoother assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BATTERY_GAUGE_SMOOTHER_CORE_ASSERT_SVH
`define BATTERY_GAUGE_SMOOTHER_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define BGS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BGS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BGS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ sv/bgs_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery gauge smoother package
// Widths, constants, register indexes and the microcode ROM of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bgs_pkg;

    // field and state widths
    localparam int RAW_W      = 12;
    localparam int TDATA_IN_W = 16;
    localparam int BAT_W      = 18;
    localparam int PCT_W      = 7;
    localparam int CAVG_W     = 12;
    localparam int VACC_W     = 25;
    localparam int CACC_W     = 17;
    localparam int SCALE_W    = 16;
    localparam int MV_W       = 16;
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_RAW_W  = 24;   // raw * 3550 fits in 24 bits
    localparam int PCT_DVD_W  = 25;   // (avg - empty) * 100
    localparam int NUM_W      = 32;
    localparam int DIV_CNT_W  = 5;
    localparam int OUT_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int STEP_W     = 5;
    localparam int RECIP_W      = 29;
    localparam int RECIP_PROD_W = NUM_W + RECIP_W;
    localparam int RECIP_SHIFT  = 38;

    localparam int VOLT_SHIFT = 7;
    localparam int CUR_SHIFT  = 5;

    localparam logic [11:0]    ADC_FULL_MV = 12'd3550;
    localparam logic [9:0]     DIV_MILLI   = 10'd1000;
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
    localparam logic [PCT_W-1:0] PCT_NO_ADC = 7'd50;
    // ceil(2^38 / 1000): (x * RECIP_MILLI) >> 38 is floor(x / 1000) for any 32-bit x
    localparam logic [RECIP_W-1:0] RECIP_MILLI = 29'd274877907;

    localparam logic [BAT_W-1:0]   EMPTY_RST = 18'd21000;
    localparam logic [BAT_W-1:0]   FULL_RST  = 18'd27600;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd11000;
    localparam logic [BAT_W-1:0]   BAT_RST   = 18'd27600;

    localparam logic [DIV_CNT_W-1:0] DIV_PCT_LAST = 5'd24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMPTY_MV      = 2'd0,
        REG_FULL_MV       = 2'd1,
        REG_DIVIDER_SCALE = 2'd2
    } cfg_reg_t;

    typedef logic [STEP_W-1:0] step_t;

    // microcode addresses
    localparam step_t S_IDLE      = 5'd0;
    localparam step_t S_MUL_RAW   = 5'd1;
    localparam step_t S_MV        = 5'd2;
    localparam step_t S_MUL_SCALE = 5'd3;
    localparam step_t S_BAT_RECIP = 5'd4;
    localparam step_t S_BAT       = 5'd5;
    localparam step_t S_VAVG      = 5'd6;
    localparam step_t S_CHK_LOW   = 5'd7;
    localparam step_t S_CHK_SPAN  = 5'd8;
    localparam step_t S_MUL_PCT   = 5'd9;
    localparam step_t S_DIV_PCT   = 5'd10;
    localparam step_t S_PCT_STEP  = 5'd11;
    localparam step_t S_PCT_DIV   = 5'd12;
    localparam step_t S_PCT_ZERO  = 5'd13;
    localparam step_t S_PCT_FULL  = 5'd14;
    localparam step_t S_CUR_ADD   = 5'd15;
    localparam step_t S_CUR_AVG   = 5'd16;
    localparam step_t S_DONE      = 5'd17;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_MUL_RAW,
        OP_MV,
        OP_MUL_SCALE,
        OP_BAT_RECIP,
        OP_DIV_STEP,
        OP_BAT,
        OP_VAVG,
        OP_MUL_PCT,
        OP_DIV_PCT,
        OP_PCT_DIV,
        OP_PCT_ZERO,
        OP_PCT_FULL,
        OP_CUR_ADD,
        OP_CUR_AVG,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_IN_VALID,
        C_CURRENT,
        C_DIV_DONE,
        C_BELOW,
        C_NO_SPAN,
        C_OUT_FREE
    } cond_t;

    // hold: stay on this step while the condition is false
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t uword(input op_t op, input cond_t cond, input logic hold,
                                    input step_t target);
        ctrl_t w;
        w.op     = op;
        w.cond   = cond;
        w.hold   = hold;
        w.target = target;
        return w;
    endfunction

    function automatic ctrl_t ucode_rom(input step_t addr);
        ctrl_t w;
        case (addr)
            S_IDLE:      w = uword(OP_LATCH,     C_IN_VALID, 1'b1, S_MUL_RAW);
            S_MUL_RAW:   w = uword(OP_MUL_RAW,   C_NONE,     1'b0, S_IDLE);
            S_MV:        w = uword(OP_MV,        C_CURRENT,  1'b0, S_CUR_ADD);
            S_MUL_SCALE: w = uword(OP_MUL_SCALE, C_NONE,     1'b0, S_IDLE);
            S_BAT_RECIP: w = uword(OP_BAT_RECIP, C_NONE,     1'b0, S_IDLE);
            S_BAT:       w = uword(OP_BAT,       C_NONE,     1'b0, S_IDLE);
            S_VAVG:      w = uword(OP_VAVG,      C_NONE,     1'b0, S_IDLE);
            S_CHK_LOW:   w = uword(OP_NOP,       C_BELOW,    1'b0, S_PCT_ZERO);
            S_CHK_SPAN:  w = uword(OP_NOP,       C_NO_SPAN,  1'b0, S_PCT_FULL);
            S_MUL_PCT:   w = uword(OP_MUL_PCT,   C_NONE,     1'b0, S_IDLE);
            S_DIV_PCT:   w = uword(OP_DIV_PCT,   C_NONE,     1'b0, S_IDLE);
            S_PCT_STEP:  w = uword(OP_DIV_STEP,  C_DIV_DONE, 1'b1, S_PCT_DIV);
            S_PCT_DIV:   w = uword(OP_PCT_DIV,   C_ALWAYS,   1'b0, S_DONE);
            S_PCT_ZERO:  w = uword(OP_PCT_ZERO,  C_ALWAYS,   1'b0, S_DONE);
            S_PCT_FULL:  w = uword(OP_PCT_FULL,  C_ALWAYS,   1'b0, S_DONE);
            S_CUR_ADD:   w = uword(OP_CUR_ADD,   C_NONE,     1'b0, S_IDLE);
            S_CUR_AVG:   w = uword(OP_CUR_AVG,   C_NONE,     1'b0, S_IDLE);
            S_DONE:      w = uword(OP_OUT,       C_OUT_FREE, 1'b1, S_IDLE);
            default:     w = uword(OP_NOP,       C_ALWAYS,   1'b0, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ sv/battery_gauge_smoother_core.sv @@
// ----------------------------------------------------------------------------
// Battery gauge smoother core
// Converts tagged ADC samples to battery mV, charge percent and smoothed
// current, driven by a small microcoded sequencer over a shared datapath.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: req_type, tdata: raw_sample
//  m_*       out  m_tvalid/m_tready  tdata: battery_mv, charge_percent,
//                                    current_avg_mv
//  cfg_*     in   cfg_wr_en          cfg_index, cfg_wdata (write only)
//
//  Voltage transaction: the 25-step restoring divide for the percentage
//  dominates; it is skipped when below empty or with full <= empty, and the
//  /1000 is one reciprocal multiply. One transaction in flight; the result
//  register lets the next one enter while the result waits. A stalled
//  m_tready holds the sequencer at its last step. Reset is synchronous and
//  active low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "battery_gauge_smoother_core_assert.svh"

module battery_gauge_smoother_core
    import bgs_pkg::*;
#(
    parameter int unsigned ADC_BITS = 12
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_IN_W-1:0] s_tdata,   // [11:0] raw_sample
    input  wire logic [0:0]            s_tuser,   // [0] req_type
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata    // [17:0] battery_mv,
                                                  // [24:18] charge_percent,
                                                  // [36:25] current_avg_mv
);

    // control and state
    step_t                pc_reg, pc_next;
    logic                 m_valid_reg, m_valid_next;
    logic [BAT_W-1:0]     empty_reg, empty_next;
    logic [BAT_W-1:0]     full_reg, full_next;
    logic [SCALE_W-1:0]   scale_reg, scale_next;
    logic [BAT_W-1:0]     last_bat_reg, last_bat_next;
    logic [VACC_W-1:0]    vacc_reg, vacc_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic [CACC_W-1:0]    cacc_reg, cacc_next;
    logic [CAVG_W-1:0]    cavg_reg, cavg_next;

    // datapath
    logic [RAW_W-1:0]     raw_reg, raw_next;
    logic                 type_reg, type_next;
    logic [MV_W-1:0]      mv_reg, mv_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [BAT_W-1:0]     rem_reg, rem_next;
    logic [BAT_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [BAT_W-1:0]     vavg_reg, vavg_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    ctrl_t                ctrl;
    logic                 cond_true;
    logic                 out_free;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    product;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [BAT_W:0]       rem_shift;
    logic [BAT_W+1:0]     trial;
    logic                 q_bit;
    logic [BAT_W-1:0]     bat_sat;
    logic [CAVG_W-1:0]    cur_sat;
    logic [PCT_W-1:0]     pct_out;

    assign ctrl     = ucode_rom(pc_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (pc_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;

    // shared multiplier operand select
    always_comb begin
        case (ctrl.op)
            OP_MUL_RAW: begin
                mul_a = MUL_A_W'(raw_reg);
                mul_b = MUL_B_W'(ADC_FULL_MV);
            end
            OP_MUL_SCALE: begin
                mul_a = MUL_A_W'(mv_reg);
                mul_b = scale_reg;
            end
            OP_MUL_PCT: begin
                mul_a = vavg_reg - empty_reg;
                mul_b = MUL_B_W'(PCT_SCALE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // divide by 1000 as a multiply by the scaled reciprocal
    assign recip_prod = RECIP_PROD_W'(prod_reg[NUM_W-1:0]) * RECIP_PROD_W'(RECIP_MILLI);

    // restoring divider, one quotient bit per cycle
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign trial     = {1'b0, rem_shift} - (BAT_W+2)'(den_reg);
    assign q_bit     = !trial[BAT_W+1];

    assign bat_sat = (|num_reg[NUM_W-1:BAT_W]) ? '1 : num_reg[BAT_W-1:0];
    assign cur_sat = (|mv_reg[MV_W-1:CAVG_W]) ? '1 : mv_reg[CAVG_W-1:0];
    assign pct_out = (last_bat_reg == '0) ? PCT_NO_ADC : pct_reg;

    always_comb begin
        case (ctrl.cond)
            C_NONE:     cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_IN_VALID: cond_true = s_tvalid;
            C_CURRENT:  cond_true = type_reg;
            C_DIV_DONE: cond_true = (cnt_reg == '0);
            C_BELOW:    cond_true = (vavg_reg < empty_reg);
            C_NO_SPAN:  cond_true = (full_reg <= empty_reg);
            C_OUT_FREE: cond_true = out_free;
            default:    cond_true = 1'b0;
        endcase
    end

    always_comb begin
        pc_next       = cond_true ? ctrl.target
                      : (ctrl.hold ? pc_reg : step_t'(pc_reg + 1'b1));
        m_valid_next  = m_valid_reg && !m_tready;
        empty_next    = empty_reg;
        full_next     = full_reg;
        scale_next    = scale_reg;
        last_bat_next = last_bat_reg;
        vacc_next     = vacc_reg;
        pct_next      = pct_reg;
        cacc_next     = cacc_reg;
        cavg_next     = cavg_reg;
        raw_next      = raw_reg;
        type_next     = type_reg;
        mv_next       = mv_reg;
        prod_next     = prod_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        cnt_next      = cnt_reg;
        vavg_next     = vavg_reg;
        out_data_next = out_data_reg;

        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_EMPTY_MV:      empty_next = cfg_wdata;
                REG_FULL_MV:       full_next  = cfg_wdata;
                REG_DIVIDER_SCALE: scale_next = cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end

        case (ctrl.op)
            OP_LATCH: begin
                if (s_tvalid) begin
                    raw_next  = s_tdata[RAW_W-1:0];
                    type_next = s_tuser[0];
                end
            end
            OP_MUL_RAW, OP_MUL_SCALE, OP_MUL_PCT: begin
                prod_next = product;
            end
            OP_MV: begin
                mv_next = MV_W'(prod_reg[MUL_RAW_W-1:0] >> ADC_BITS);
            end
            OP_BAT_RECIP: begin
                num_next = NUM_W'(recip_prod >> RECIP_SHIFT);
            end
            OP_DIV_STEP: begin
                rem_next = q_bit ? trial[BAT_W-1:0] : rem_shift[BAT_W-1:0];
                num_next = {num_reg[NUM_W-2:0], q_bit};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_BAT: begin
                last_bat_next = bat_sat;
                vacc_next     = vacc_reg + VACC_W'(bat_sat);
            end
            OP_VAVG: begin
                vavg_next = BAT_W'(vacc_reg >> VOLT_SHIFT);
                vacc_next = vacc_reg - (vacc_reg >> VOLT_SHIFT);
            end
            OP_DIV_PCT: begin
                // dividend left-aligned so 25 steps leave the quotient in the low bits
                num_next = {prod_reg[PCT_DVD_W-1:0], {(NUM_W-PCT_DVD_W){1'b0}}};
                den_next = full_reg - empty_reg;
                rem_next = '0;
                cnt_next = DIV_PCT_LAST;
            end
            OP_PCT_DIV: begin
                pct_next = (num_reg[PCT_DVD_W-1:0] > PCT_DVD_W'(PCT_SCALE))
                         ? PCT_SCALE : num_reg[PCT_W-1:0];
            end
            OP_PCT_ZERO: pct_next = '0;
            OP_PCT_FULL: pct_next = PCT_SCALE;
            OP_CUR_ADD: begin
                cacc_next = cacc_reg + CACC_W'(cur_sat);
            end
            OP_CUR_AVG: begin
                cavg_next = CAVG_W'(cacc_reg >> CUR_SHIFT);
                cacc_next = cacc_reg - (cacc_reg >> CUR_SHIFT);
            end
            OP_OUT: begin
                if (out_free) begin
                    out_data_next = {{(OUT_W-CAVG_W-PCT_W-BAT_W){1'b0}},
                                     cavg_reg, pct_out, last_bat_reg};
                    m_valid_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= S_IDLE;
            m_valid_reg  <= 1'b0;
            empty_reg    <= EMPTY_RST;
            full_reg     <= FULL_RST;
            scale_reg    <= SCALE_RST;
            last_bat_reg <= BAT_RST;
            vacc_reg     <= '0;
            pct_reg      <= '0;
            cacc_reg     <= '0;
            cavg_reg     <= '0;
        end else begin
            pc_reg       <= pc_next;
            m_valid_reg  <= m_valid_next;
            empty_reg    <= empty_next;
            full_reg     <= full_next;
            scale_reg    <= scale_next;
            last_bat_reg <= last_bat_next;
            vacc_reg     <= vacc_next;
            pct_reg      <= pct_next;
            cacc_reg     <= cacc_next;
            cavg_reg     <= cavg_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg      <= raw_next;
        type_reg     <= type_next;
        mv_reg       <= mv_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        cnt_reg      <= cnt_next;
        vavg_reg     <= vavg_next;
        out_data_reg <= out_data_next;
    end

    // one transaction at a time
    `BGS_ASSERT_NEXT(a_single_txn, aclk, aresetn, s_tvalid && s_tready, !s_tready, "bgs: second transaction accepted")
    // the span branch must keep a zero divisor out of the divider
    `BGS_ASSERT_IMPL(a_den_nonzero, aclk, aresetn, pc_reg == S_PCT_STEP, den_reg != '0, "bgs: divide by zero")
    `BGS_ASSERT_IMPL(a_pct_range, aclk, aresetn, 1'b1, pct_reg <= PCT_SCALE, "bgs: percent above 100")
    `BGS_ASSERT_IMPL(a_no_adc_pct, aclk, aresetn, m_tvalid && m_tdata[BAT_W-1:0] == '0, m_tdata[BAT_W+PCT_W-1:BAT_W] == PCT_NO_ADC, "bgs: zero battery without 50 percent")

endmodule

`default_nettype wire
